### rtl/hnss_pkg.sv
// Shared note type, accidental codes and pitch key functions for the held note set.
package hnss_pkg;

  localparam int LETTER_W = 3;
  localparam int ACC_W    = 2;
  localparam int OCTAVE_W = 4;
  localparam int RANK_W   = 4;
  localparam int KEY_W    = OCTAVE_W + RANK_W;
  localparam int TDATA_W  = 16;

  localparam logic [LETTER_W-1:0] LETTER_C   = 3'd0;
  localparam logic [LETTER_W-1:0] LETTER_MAX = 3'd6;

  localparam logic [ACC_W-1:0] ACC_NATURAL = 2'b00;
  localparam logic [ACC_W-1:0] ACC_SHARP   = 2'b01;
  localparam logic [ACC_W-1:0] ACC_INVALID = 2'b10;
  localparam logic [ACC_W-1:0] ACC_FLAT    = 2'b11;

  localparam logic ACTION_ON  = 1'b0;
  localparam logic ACTION_OFF = 1'b1;

  typedef struct packed {
    logic [OCTAVE_W-1:0] octave;
    logic [ACC_W-1:0]    acc;
    logic [LETTER_W-1:0] letter;
  } note_t;

  localparam int NOTE_W = $bits(note_t);

  function automatic logic [RANK_W-1:0] base_rank(input logic [LETTER_W-1:0] letter);
    logic [RANK_W-1:0] r;
    unique case (letter)
      3'd0:    r = 4'd0;
      3'd1:    r = 4'd2;
      3'd2:    r = 4'd4;
      3'd3:    r = 4'd5;
      3'd4:    r = 4'd7;
      3'd5:    r = 4'd9;
      3'd6:    r = 4'd11;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] note_key(input note_t n);
    logic [RANK_W-1:0] r;
    r = base_rank(n.letter);
    if (n.acc == ACC_SHARP) begin
      r = r + 4'd1;
    end else if (n.acc == ACC_FLAT && n.letter != LETTER_C) begin
      r = r - 4'd1;
    end
    return {n.octave, r};
  endfunction

endpackage

### rtl/hnss_mem.sv
// Note store: synchronous single-write, single-read memory with registered read data.
module hnss_mem #(
  parameter int DEPTH = 12,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output hnss_pkg::note_t   rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  hnss_pkg::note_t   wr_data
);

  hnss_pkg::note_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### rtl/held_note_sorted_set_unit.sv
// Top level of the held note set: merge sequencer around the note store and output register.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata, s_tuser) takes one note event per
//   transaction: s_tuser is the action (0 note on, 1 note off) and s_tdata carries the
//   letter, accidental and octave. After each event the master channel (m_tvalid,
//   m_tready, m_tdata, m_tuser, m_tlast) sends the whole held set in ascending pitch
//   order, one note per transaction, with m_tlast on the final one. An empty set is
//   sent as one transaction with m_tuser high and zero note fields.
//   The notes live in a one-port-read, one-port-write memory kept in sorted order.
//   Each event is one merge pass over the memory: every cycle in which the output can
//   advance reads at most one old entry, writes at most one entry of the new order and
//   hands at most one note to the output stage. s_tready stays low for the whole pass
//   and rises again when the pass ends. Each note waits in a pending register until the
//   next note or the end of the pass moves it into the output register on the master
//   channel. The pass reads the held notes one at a time through the single read port.
//   Reset empties the set at once; the memory contents need no clearing.
//   When m_tready is low while a note waits on the master channel, the whole pass holds
//   in place and resumes without loss.
module held_note_sorted_set_unit #(
  parameter int MAX_NOTES = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [2:0] note_letter, [4:3] accidental, [8:5] octave
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] out_letter, [4:3] out_accidental, [8:5] out_octave
  output logic        m_tuser,   // [0] set_empty
  output logic        m_tlast
);

  localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CW = $clog2(MAX_NOTES + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_NOTES);
  localparam logic [CW-1:0] ONE = CW'(1);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t          state;
  hnss_pkg::note_t cur;
  logic            add_en;
  logic            rem_en;
  logic            done;
  logic [CW-1:0]   held_count;
  logic [CW-1:0]   rd_idx;
  logic [CW-1:0]   wr_idx;
  logic            pend_valid;
  hnss_pkg::note_t pend;
  logic            out_valid;
  hnss_pkg::note_t out_note;
  logic            out_empty;
  logic            out_last;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  hnss_pkg::note_t rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  hnss_pkg::note_t wr_data;

  hnss_pkg::note_t in_note;
  logic [hnss_pkg::ACC_W-1:0] in_acc;
  logic            in_accept;
  logic            adv;
  logic            have_old;
  logic [hnss_pkg::KEY_W-1:0] new_key;
  logic [hnss_pkg::KEY_W-1:0] old_key;
  logic            emit;
  hnss_pkg::note_t emit_note;
  logic            consume;
  logic            finish;
  logic            set_done;

  hnss_mem #(
    .DEPTH (MAX_NOTES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_acc = (s_tdata[4:3] == hnss_pkg::ACC_INVALID) ? hnss_pkg::ACC_NATURAL
                                                           : s_tdata[4:3];
  assign in_note.letter = s_tdata[2:0];
  assign in_note.acc    = in_acc;
  assign in_note.octave = s_tdata[8:5];

  assign s_tready  = (state == IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign adv       = !out_valid || m_tready;
  assign have_old  = (rd_idx < held_count);
  assign new_key   = hnss_pkg::note_key(cur);
  assign old_key   = hnss_pkg::note_key(rd_data);

  always_comb begin
    emit      = 1'b0;
    emit_note = rd_data;
    consume   = 1'b0;
    finish    = 1'b0;
    set_done  = 1'b0;
    if (state == RUN && adv) begin
      priority if (have_old && add_en && !done && new_key < old_key) begin
        emit      = 1'b1;
        emit_note = cur;
        set_done  = 1'b1;
      end else if (have_old && rem_en && !done && new_key == old_key) begin
        consume  = 1'b1;
        set_done = 1'b1;
      end else if (have_old) begin
        emit     = 1'b1;
        consume  = 1'b1;
        set_done = add_en && (new_key == old_key);
      end else if (add_en && !done) begin
        emit      = 1'b1;
        emit_note = cur;
        set_done  = 1'b1;
      end else begin
        finish = 1'b1;
      end
    end
  end

  always_comb begin
    rd_en   = in_accept || consume;
    rd_addr = in_accept ? '0 : AW'(rd_idx + ONE);
    wr_en   = emit;
    wr_addr = wr_idx[AW-1:0];
    wr_data = emit_note;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      held_count <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      done       <= 1'b0;
      add_en     <= 1'b0;
      rem_en     <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_accept) begin
            cur    <= in_note;
            add_en <= (s_tuser == hnss_pkg::ACTION_ON)
                      && (in_note.letter <= hnss_pkg::LETTER_MAX)
                      && (held_count < MAX_COUNT);
            rem_en <= (s_tuser == hnss_pkg::ACTION_OFF)
                      && (in_note.letter <= hnss_pkg::LETTER_MAX);
            done   <= 1'b0;
            rd_idx <= '0;
            wr_idx <= '0;
            state  <= RUN;
          end
        end
        RUN: begin
          if (set_done) begin
            done <= 1'b1;
          end
          if (consume) begin
            rd_idx <= rd_idx + ONE;
          end
          if (emit) begin
            wr_idx     <= wr_idx + ONE;
            pend       <= emit_note;
            pend_valid <= 1'b1;
          end
          if (finish) begin
            held_count <= wr_idx;
            pend_valid <= 1'b0;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase

      if ((emit && pend_valid) || finish) begin
        out_valid <= 1'b1;
        out_note  <= pend_valid ? pend : '0;
        out_empty <= !pend_valid;
        out_last  <= finish;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = 16'(out_note);
  assign m_tuser  = out_empty;
  assign m_tlast  = out_last;

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= MAX_COUNT)
    else $error("held note count exceeds capacity");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 16'd0))
    else $error("empty marker must be a lone zero transaction");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !pend_valid)
    else $error("held note left pending after a pass");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_idx < MAX_COUNT))
    else $error("note store write beyond capacity");

endmodule

### dv/hnss_checker.sv
// Checker for the held note set: tracks the sorted set from note events and compares results.
`timescale 1ns / 1ps
module hnss_checker #(
  parameter int MAX_NOTES = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [2:0] note_letter, [4:3] accidental, [8:5] octave
  input  logic        s_tuser,   // [0] action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [2:0] out_letter, [4:3] out_accidental, [8:5] out_octave
  input  logic        m_tuser,   // [0] set_empty
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [hnss_pkg::TDATA_W-1:0] data;
    logic                         empty;
    logic                         last;
  } sorted_note_t;

  hnss_pkg::note_t held_set [MAX_NOTES];
  int              held_total = 0;
  sorted_note_t    sorted_due [$];

  function automatic logic [hnss_pkg::KEY_W-1:0] pitch_of(input hnss_pkg::note_t n);
    logic [hnss_pkg::RANK_W-1:0] rank;
    case (n.letter)
      3'd1:    rank = 4'd2;
      3'd2:    rank = 4'd4;
      3'd3:    rank = 4'd5;
      3'd4:    rank = 4'd7;
      3'd5:    rank = 4'd9;
      3'd6:    rank = 4'd11;
      default: rank = 4'd0;
    endcase
    if (n.acc == hnss_pkg::ACC_SHARP) begin
      rank = rank + 4'd1;
    end else if (n.acc == hnss_pkg::ACC_FLAT && n.letter != hnss_pkg::LETTER_C) begin
      rank = rank - 4'd1;
    end
    return {n.octave, rank};
  endfunction

  function automatic void apply_note_event(input logic action, input hnss_pkg::note_t n);
    hnss_pkg::note_t             entry;
    logic [hnss_pkg::KEY_W-1:0]  key;
    int                          pos;
    bit                          found;
    entry = n;
    pos = 0;
    found = 1'b0;
    if (entry.letter <= hnss_pkg::LETTER_MAX) begin
      if (entry.acc == hnss_pkg::ACC_INVALID) begin
        entry.acc = hnss_pkg::ACC_NATURAL;
      end
      key = pitch_of(entry);
      while (pos < held_total && pitch_of(held_set[pos]) < key) begin
        pos++;
      end
      found = (pos < held_total) && (pitch_of(held_set[pos]) == key);
      if (action == hnss_pkg::ACTION_ON) begin
        if (!found && held_total < MAX_NOTES) begin
          for (int i = held_total; i > pos; i--) begin
            held_set[i] = held_set[i-1];
          end
          held_set[pos] = entry;
          held_total++;
        end
      end else if (found) begin
        for (int i = pos; i + 1 < held_total; i++) begin
          held_set[i] = held_set[i+1];
        end
        held_total--;
      end
    end
    if (held_total == 0) begin
      sorted_due.push_back({{hnss_pkg::TDATA_W{1'b0}}, 1'b1, 1'b1});
    end else begin
      for (int i = 0; i < held_total; i++) begin
        sorted_due.push_back({{(hnss_pkg::TDATA_W-hnss_pkg::NOTE_W){1'b0}}, held_set[i],
                              1'b0, i == held_total - 1});
      end
    end
  endfunction

  always @(posedge clk) begin
    sorted_note_t got;
    sorted_note_t want;
    if (rst) begin
      held_total = 0;
      sorted_due.delete();
      errors <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata, m_tuser, m_tlast};
        if (sorted_due.size() == 0) begin
          $display("%0t: unexpected: expected none, actual data=%h empty=%b last=%b",
                   $time, got.data, got.empty, got.last);
          errors <= errors + 1;
        end else begin
          want = sorted_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b",
                     $time, want.data, want.empty, want.last,
                     got.data, got.empty, got.last);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_note_event(s_tuser, s_tdata[hnss_pkg::NOTE_W-1:0]);
      end
    end
    pending <= sorted_due.size();
  end

endmodule

### dv/tb_top.sv
// Testbench top for the held note set: drives note events and backpressure, reports the verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_EVENTS = 138;

  localparam logic [hnss_pkg::LETTER_W-1:0] LETTER_D   = 3'd1;
  localparam logic [hnss_pkg::LETTER_W-1:0] LETTER_E   = 3'd2;
  localparam logic [hnss_pkg::LETTER_W-1:0] LETTER_F   = 3'd3;
  localparam logic [hnss_pkg::LETTER_W-1:0] LETTER_G   = 3'd4;
  localparam logic [hnss_pkg::LETTER_W-1:0] LETTER_A   = 3'd5;
  localparam logic [hnss_pkg::LETTER_W-1:0] LETTER_B   = 3'd6;
  localparam logic [hnss_pkg::LETTER_W-1:0] LETTER_BAD = 3'd7;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  int          errors;
  int          pending;
  int          cycles   = 0;
  bit          steady   = 1'b0;

  held_note_sorted_set_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  hnss_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 20);
  end

  task automatic send_note_event(input logic action,
                                 input logic [hnss_pkg::LETTER_W-1:0] letter,
                                 input logic [hnss_pkg::ACC_W-1:0] acc,
                                 input logic [hnss_pkg::OCTAVE_W-1:0] octave);
    if (!steady && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {7'd0, octave, acc, letter};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_set_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random_note_event();
    logic                          action;
    logic [hnss_pkg::LETTER_W-1:0] letter;
    logic [hnss_pkg::ACC_W-1:0]    acc;
    logic [hnss_pkg::OCTAVE_W-1:0] octave;
    int                            pick;
    action = ($urandom_range(99) < 45) ? hnss_pkg::ACTION_OFF : hnss_pkg::ACTION_ON;
    letter = ($urandom_range(99) < 5) ? LETTER_BAD
                                      : hnss_pkg::LETTER_W'($urandom_range(6));
    acc    = hnss_pkg::ACC_W'($urandom_range(3));
    pick   = $urandom_range(99);
    // A narrow pitch range keeps note-offs hitting held notes and lets the set fill.
    if (pick < 70) begin
      octave = 4'd4;
    end else if (pick < 90) begin
      octave = hnss_pkg::OCTAVE_W'($urandom_range(5, 3));
    end else begin
      octave = hnss_pkg::OCTAVE_W'($urandom_range(15));
    end
    send_note_event(action, letter, acc, octave);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_note_event(hnss_pkg::ACTION_OFF, hnss_pkg::LETTER_C, hnss_pkg::ACC_NATURAL, 4'd0);
    send_note_event(hnss_pkg::ACTION_ON, hnss_pkg::LETTER_C, hnss_pkg::ACC_FLAT, 4'd0);
    send_note_event(hnss_pkg::ACTION_ON, hnss_pkg::LETTER_C, hnss_pkg::ACC_NATURAL, 4'd0);
    send_note_event(hnss_pkg::ACTION_ON, LETTER_B, hnss_pkg::ACC_SHARP, 4'd0);
    send_note_event(hnss_pkg::ACTION_ON, hnss_pkg::LETTER_C, hnss_pkg::ACC_NATURAL, 4'd1);
    send_note_event(hnss_pkg::ACTION_ON, LETTER_BAD, hnss_pkg::ACC_SHARP, 4'd2);
    send_note_event(hnss_pkg::ACTION_ON, LETTER_D, hnss_pkg::ACC_INVALID, 4'd15);
    send_note_event(hnss_pkg::ACTION_ON, LETTER_E, hnss_pkg::ACC_SHARP, 4'd9);
    send_note_event(hnss_pkg::ACTION_ON, LETTER_F, hnss_pkg::ACC_NATURAL, 4'd9);
    send_note_event(hnss_pkg::ACTION_ON, LETTER_D, hnss_pkg::ACC_FLAT, 4'd4);
    send_note_event(hnss_pkg::ACTION_ON, hnss_pkg::LETTER_C, hnss_pkg::ACC_SHARP, 4'd4);
    send_note_event(hnss_pkg::ACTION_ON, LETTER_A, hnss_pkg::ACC_NATURAL, 4'd5);
    send_note_event(hnss_pkg::ACTION_ON, LETTER_B, hnss_pkg::ACC_FLAT, 4'd2);
    send_note_event(hnss_pkg::ACTION_ON, LETTER_G, hnss_pkg::ACC_SHARP, 4'd3);
    send_note_event(hnss_pkg::ACTION_ON, LETTER_F, hnss_pkg::ACC_FLAT, 4'd7);
    send_note_event(hnss_pkg::ACTION_ON, LETTER_A, hnss_pkg::ACC_FLAT, 4'd10);
    send_note_event(hnss_pkg::ACTION_ON, LETTER_E, hnss_pkg::ACC_NATURAL, 4'd8);
    send_note_event(hnss_pkg::ACTION_ON, LETTER_G, hnss_pkg::ACC_NATURAL, 4'd6);
    send_note_event(hnss_pkg::ACTION_OFF, LETTER_G, hnss_pkg::ACC_NATURAL, 4'd6);
    send_note_event(hnss_pkg::ACTION_OFF, LETTER_F, hnss_pkg::ACC_NATURAL, 4'd9);
    send_note_event(hnss_pkg::ACTION_OFF, LETTER_BAD, hnss_pkg::ACC_INVALID, 4'd0);
    send_note_event(hnss_pkg::ACTION_OFF, hnss_pkg::LETTER_C, hnss_pkg::ACC_NATURAL, 4'd0);
    wait_set_drained();

    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      steady = (n >= 60 && n < 110);
      if (n == 80) begin
        wait_set_drained();
      end
      send_random_note_event();
    end
    steady = 1'b0;
    wait_set_drained();
    repeat (40) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
